// ===== rtl/upd_pkg.sv =====
package upd_pkg;

    // offset counter width and the width of the reported offset
    localparam int OFFSET_BITS = 16;
    localparam int FAIL_OFF_W  = 16;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // special characters
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [4:0] BAD_DIGIT  = 5'h1f;

    // result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [7:0]            data_byte;
        logic [FAIL_OFF_W-1:0] fail_offset;
        logic                  end_mark;
    } result_t;

    // up to two results written into the queue in one cycle, slot 0 first
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        case (c) inside
            [8'h30:8'h39]: v = 5'(c - 8'h30);
            [8'h61:8'h66]: v = 5'(c - 8'h61 + 8'd10);
            [8'h41:8'h46]: v = 5'(c - 8'h41 + 8'd10);
            default:       v = BAD_DIGIT;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/upd_core.sv =====
module upd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  logic [7:0]      in_byte,
    input  logic            last,
    input  logic            room,
    output logic            held,
    output upd_pkg::push_t  push
);
    import upd_pkg::*;

    logic                   held_reg;
    logic                   held_next;
    logic [7:0]             byte_reg;
    logic                   last_reg;
    logic                   accept;
    logic                   process;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             hi_reg, hi_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] esc_reg, esc_next;
    logic                   failed_reg, failed_next;
    logic [OFFSET_BITS-1:0] fo_reg, fo_next;

    logic [4:0]             digit;
    logic                   data_v;
    logic [7:0]             data_val;
    result_t                data_res;
    result_t                stat_res;

    assign accept     = byte_valid && !byte_stall;
    assign process    = held_reg && room;
    assign byte_stall = held_reg && !room;
    assign held       = held_reg;
    assign held_next  = accept ? 1'b1 : (process ? 1'b0 : held_reg);
    assign digit      = hex_value(byte_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        hi_next     = hi_reg;
        off_next    = off_reg;
        esc_next    = esc_reg;
        failed_next = failed_reg;
        fo_next     = fo_reg;
        data_v      = 1'b0;
        data_val    = '0;
        stat_res    = '{kind: KIND_OK, data_byte: '0, fail_offset: '0, end_mark: 1'b1};

        if (process)
        begin
            if (!failed_reg)
            begin
                if (phase_reg == PH_PLAIN)
                begin
                    if (byte_reg == CH_PERCENT)
                    begin
                        esc_next   = off_reg;
                        phase_next = PH_HIGH;
                    end
                    else if (byte_reg == CH_PLUS)
                    begin
                        data_v   = 1'b1;
                        data_val = CH_SPACE;
                    end
                    else
                    begin
                        data_v   = 1'b1;
                        data_val = byte_reg;
                    end
                end
                else if (digit == BAD_DIGIT)
                begin
                    // bad hex digit fails at the percent sign
                    failed_next = 1'b1;
                    fo_next     = esc_reg;
                    phase_next  = PH_PLAIN;
                end
                else if (phase_reg == PH_HIGH)
                begin
                    hi_next    = digit[3:0];
                    phase_next = PH_LOW;
                end
                else
                begin
                    data_v     = 1'b1;
                    data_val   = {hi_reg, digit[3:0]};
                    phase_next = PH_PLAIN;
                end
            end

            // saturating offset
            if (off_reg != OFFSET_MAX)
            begin
                off_next = off_reg + 1'b1;
            end

            if (last_reg)
            begin
                // escape cut off by the end of the string
                if (!failed_next && phase_next != PH_PLAIN)
                begin
                    failed_next = 1'b1;
                    fo_next     = esc_next;
                end
                if (failed_next)
                begin
                    stat_res.kind        = KIND_FAIL;
                    stat_res.fail_offset = FAIL_OFF_W'(fo_next);
                end
                phase_next  = PH_PLAIN;
                hi_next     = '0;
                off_next    = '0;
                esc_next    = '0;
                failed_next = 1'b0;
                fo_next     = '0;
            end
        end
    end

    always_comb
    begin
        data_res = '{kind: KIND_DATA, data_byte: data_val, fail_offset: '0, end_mark: 1'b0};
        push     = '0;
        if (process)
        begin
            if (data_v)
            begin
                push.v0 = 1'b1;
                push.r0 = data_res;
                push.v1 = last_reg;
                push.r1 = stat_res;
            end
            else
            begin
                push.v0 = last_reg;
                push.r0 = stat_res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= 1'b0;
            phase_reg  <= PH_PLAIN;
            hi_reg     <= '0;
            off_reg    <= '0;
            esc_reg    <= '0;
            failed_reg <= 1'b0;
            fo_reg     <= '0;
        end
        else
        begin
            held_reg   <= held_next;
            phase_reg  <= phase_next;
            hi_reg     <= hi_next;
            off_reg    <= off_next;
            esc_reg    <= esc_next;
            failed_reg <= failed_next;
            fo_reg     <= fo_next;
        end
    end

endmodule

// ===== rtl/upd_queue.sv =====
module upd_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  upd_pkg::push_t                push,
    output logic                          room,
    output logic                          result_valid,
    input  logic                          result_stall,
    output upd_pkg::result_t              head
);
    import upd_pkg::*;

    result_t               mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;
    logic [RQ_PTR_W-1:0]   wr_ptr_1;
    logic [1:0]            n_push;
    logic                  pop;

    assign wr_ptr_1     = wr_ptr_reg + 1'b1;
    assign n_push       = {1'b0, push.v0} + {1'b0, push.v1};
    assign pop          = result_valid && !result_stall;
    assign result_valid = count_reg != '0;
    assign head         = mem_reg[rd_ptr_reg];
    // two free entries so any item can be taken regardless of the sink
    assign room         = count_reg <= RQ_CNT_W'(RQ_DEPTH - 2);

    assign wr_ptr_next  = wr_ptr_reg + RQ_PTR_W'(n_push);
    assign rd_ptr_next  = rd_ptr_reg + RQ_PTR_W'(pop);
    assign count_next   = count_reg + RQ_CNT_W'(n_push) - RQ_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/url_percent_decoder.sv =====
// url percent decoder: takes one escaped byte per item and gives the decoded
// string back as result items. a plus sign comes out as a space, a percent
// sign with two hex digits (either case) comes out as the byte they spell,
// and any other byte passes through. a bad hex digit, or a percent sign cut
// off by the end of the string, fails the string at the offset of that percent
// sign; no data follows a failure. the item flagged last produces a status
// result (kind 1 success, kind 2 failure with its offset, end_mark set) after
// any data it yields, and the decoder then starts fresh for the next string.
// throughput is one byte per cycle while the result queue has room: a byte
// sits in an input register, one pass of decode logic updates the escape
// state and writes its results into a four-entry result queue, and the queue
// hands out one result per cycle unless result_stall holds it. a final byte
// that also yields data gives two results, so a long run of such items is
// limited by the queue's single read port and stalls the input.
// the offset counter saturates at 65535.
module url_percent_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [15:0] fail_offset,
    output logic        end_mark
);
    import upd_pkg::*;

    push_t   push;
    result_t head;
    logic    room;
    logic    held;

    // input register, escape state and decode logic
    upd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .in_byte    (in_byte),
        .last       (last),
        .room       (room),
        .held       (held),
        .push       (push)
    );

    // result queue, written up to two at a time, read one at a time
    upd_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign kind        = head.kind;
    assign data_byte   = head.data_byte;
    assign fail_offset = head.fail_offset;
    assign end_mark    = head.end_mark;

    // stall only while a byte waits in the input register
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> held)
        else $error("stall raised with empty input register");

    // queue writes only happen for a held byte with room behind it
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.v0 || push.v1) |-> (held && room))
        else $error("result written without room");

    // second slot is used only together with the first
    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> (push.v0 && push.r1.end_mark && !push.r0.end_mark))
        else $error("result slots out of order");

    // status results carry end_mark and no data; data results carry no mark
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((end_mark && kind != KIND_DATA && data_byte == 8'd0)
                          || (!end_mark && kind == KIND_DATA && fail_offset == 16'd0)))
        else $error("malformed result");

endmodule
